### src/assert_macros.svh
// Assertion helpers for the aggregator RTL.
// Every assertion is clocked on clk_i and disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside of reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that cond implies expr in the same cycle.
`define ASSERT_IMPL(lbl, cond, expr, msg) \
  `ASSERT_CLK(lbl, (cond) |-> (expr), msg)

`endif

### src/dfpa_pkg.sv
// Types and constants of the delimited field price aggregator.
// Used by the front, queue, back and top level modules; no dependencies.
package dfpa_pkg;

  // Input item: one text byte or an end of stream marker.
  typedef struct packed {
    logic       opcode;
    logic [7:0] data_byte;
  } in_t;

  // Result item, emitted each time a line closes.
  typedef struct packed {
    logic [31:0]        record_count;
    logic [31:0]        transaction_count;
    logic signed [63:0] total_sales;
    logic signed [31:0] pending_amount;
    logic               price_valid;
    logic signed [31:0] line_price;
  } out_t;

  // Per-line summary handed from the parser to the aggregation stage.
  typedef struct packed {
    logic        price_valid;
    logic [31:0] price;
  } rec_t;

  localparam logic OP_DATA = 1'b0;
  localparam logic OP_EOS  = 1'b1;

  localparam logic [7:0] CFG_FIELD_SEP    = 8'd0;
  localparam logic [7:0] CFG_DECIMAL_MARK = 8'd1;
  localparam logic [7:0] CFG_TARGET_FIELD = 8'd2;

  localparam logic [7:0] FIELD_SEP_RESET    = 8'd124;
  localparam logic [7:0] DECIMAL_MARK_RESET = 8'd44;
  localparam logic [7:0] TARGET_FIELD_RESET = 8'd10;

  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_VTAB    = 8'd11;
  localparam logic [7:0] CH_FF      = 8'd12;
  localparam logic [7:0] CH_CR      = 8'd13;
  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [7:0] CH_PLUS    = 8'd43;
  localparam logic [7:0] CH_MINUS   = 8'd45;
  localparam logic [7:0] CH_ZERO    = 8'd48;
  localparam logic [7:0] CH_NINE    = 8'd57;

  // floor((2^63 - d) / 10) for small d; one less for the top digits.
  localparam logic [63:0] MAG_THRESHOLD = 64'd922337203685477580;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = 1;

endpackage

### src/dfpa_front.sv
// Front end: configuration registers and the per-line field parser.
// Depends on dfpa_pkg; pushes one line summary per closed line.
module dfpa_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_valid_i,
  input  logic [7:0]    cfg_index_i,
  input  logic [7:0]    cfg_data_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  dfpa_pkg::in_t in_item_i,
  input  logic          q_full_i,
  output logic          q_push_o,
  output dfpa_pkg::rec_t q_rec_o
);

  typedef enum logic [4:0] {
    PH_WAIT   = 5'b00001,
    PH_LEAD   = 5'b00010,
    PH_SIGN   = 5'b00100,
    PH_DIGITS = 5'b01000,
    PH_DONE   = 5'b10000
  } phase_e;

  logic [7:0]  sep_q, mark_q, target_q;
  logic [7:0]  sep_cnt_q, sep_cnt_d;
  phase_e      phase_q, phase_d;
  logic        neg_q, neg_d;
  logic        digit_q, digit_d;
  logic        ovf_q, ovf_d;
  logic        has_q, has_d;
  logic [63:0] mag_q, mag_d;

  logic        accept, close;
  logic [7:0]  b;
  logic        is_digit, is_space;
  logic [3:0]  dval;
  logic [63:0] thr;
  phase_e      fph;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign b          = in_item_i.data_byte;
  assign close      = (in_item_i.opcode == dfpa_pkg::OP_EOS) ? has_q
                                                             : (b == dfpa_pkg::CH_NEWLINE);
  assign is_digit   = (b >= dfpa_pkg::CH_ZERO) && (b <= dfpa_pkg::CH_NINE);
  assign is_space   = (b == dfpa_pkg::CH_SPACE) || (b == dfpa_pkg::CH_TAB) ||
                      (b == dfpa_pkg::CH_VTAB) || (b == dfpa_pkg::CH_FF) ||
                      (b == dfpa_pkg::CH_CR);
  assign dval       = b[3:0];
  assign thr        = dfpa_pkg::MAG_THRESHOLD -
                      {63'd0, (neg_q ? (dval == 4'd9) : (dval > 4'd7))};

  assign q_push_o              = accept && close;
  assign q_rec_o.price_valid   = digit_q && !ovf_q;
  assign q_rec_o.price         = !(digit_q && !ovf_q) ? 32'd0 :
                                 neg_q ? (32'd0 - mag_q[31:0]) : mag_q[31:0];

  always_comb begin
    logic add;
    add       = 1'b0;
    sep_cnt_d = sep_cnt_q;
    phase_d   = phase_q;
    neg_d     = neg_q;
    digit_d   = digit_q;
    ovf_d     = ovf_q;
    has_d     = has_q;
    mag_d     = mag_q;
    fph       = (phase_q == PH_WAIT) ? PH_LEAD : phase_q;
    if (accept) begin
      if (close) begin
        sep_cnt_d = '0;
        phase_d   = PH_WAIT;
        neg_d     = 1'b0;
        digit_d   = 1'b0;
        ovf_d     = 1'b0;
        has_d     = 1'b0;
        mag_d     = '0;
      end else if (in_item_i.opcode == dfpa_pkg::OP_DATA) begin
        has_d = 1'b1;
        if ((phase_q == PH_WAIT) && (sep_cnt_q < target_q)) begin
          if (b == sep_q) sep_cnt_d = sep_cnt_q + 8'd1;
        end else if (phase_q != PH_DONE) begin
          phase_d = fph;
          if ((b == sep_q) || (b == mark_q)) begin
            phase_d = PH_DONE;
          end else begin
            unique case (fph)
              PH_LEAD: begin
                if (is_space) begin
                  phase_d = PH_LEAD;
                end else if ((b == dfpa_pkg::CH_PLUS) || (b == dfpa_pkg::CH_MINUS)) begin
                  neg_d   = (b == dfpa_pkg::CH_MINUS);
                  phase_d = PH_SIGN;
                end else if (is_digit) begin
                  phase_d = PH_DIGITS;
                  add     = 1'b1;
                end else begin
                  phase_d = PH_DONE;
                end
              end
              PH_SIGN, PH_DIGITS: begin
                if (is_digit) begin
                  phase_d = PH_DIGITS;
                  add     = 1'b1;
                end else begin
                  phase_d = PH_DONE;
                end
              end
              default: ;
            endcase
          end
          if (add) begin
            digit_d = 1'b1;
            if (!ovf_q) begin
              if (mag_q > thr) ovf_d = 1'b1;
              else mag_d = (mag_q << 3) + (mag_q << 1) + {60'd0, dval};
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_q     <= dfpa_pkg::FIELD_SEP_RESET;
      mark_q    <= dfpa_pkg::DECIMAL_MARK_RESET;
      target_q  <= dfpa_pkg::TARGET_FIELD_RESET;
      sep_cnt_q <= '0;
      phase_q   <= PH_WAIT;
      neg_q     <= 1'b0;
      digit_q   <= 1'b0;
      ovf_q     <= 1'b0;
      has_q     <= 1'b0;
      mag_q     <= '0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == dfpa_pkg::CFG_FIELD_SEP) sep_q <= cfg_data_i;
        if (cfg_index_i == dfpa_pkg::CFG_DECIMAL_MARK) mark_q <= cfg_data_i;
        if (cfg_index_i == dfpa_pkg::CFG_TARGET_FIELD) target_q <= cfg_data_i;
      end
      sep_cnt_q <= sep_cnt_d;
      phase_q   <= phase_d;
      neg_q     <= neg_d;
      digit_q   <= digit_d;
      ovf_q     <= ovf_d;
      has_q     <= has_d;
      mag_q     <= mag_d;
    end
  end

endmodule

### src/dfpa_fifo.sv
// Two-entry queue of line summaries between parser and aggregation.
// Depends on dfpa_pkg for the entry type and depth.
module dfpa_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  dfpa_pkg::rec_t rec_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output dfpa_pkg::rec_t rec_o
);

  localparam int unsigned PW = dfpa_pkg::QUEUE_PTR_W;

  dfpa_pkg::rec_t       mem_q [dfpa_pkg::QUEUE_DEPTH];
  logic [PW-1:0]        wr_ptr_q, rd_ptr_q;
  logic [PW:0]          count_q;

  assign full_o  = (count_q == (PW+1)'(dfpa_pkg::QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign rec_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= rec_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + PW'(1);
      if (pop_i) rd_ptr_q <= rd_ptr_q + PW'(1);
      if (push_i && !pop_i) count_q <= count_q + (PW+1)'(1);
      else if (pop_i && !push_i) count_q <= count_q - (PW+1)'(1);
    end
  end

endmodule

### src/dfpa_back.sv
// Aggregation stage: running total, pending amount, counters, output register.
// Depends on dfpa_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dfpa_back #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  dfpa_pkg::rec_t q_rec_i,
  output logic           q_pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output dfpa_pkg::out_t out_item_o
);

  logic [COUNT_WIDTH-1:0] lines_q, lines_d, trans_q, trans_d;
  logic [63:0]            total_q, total_d;
  logic [31:0]            cur_q, cur_d;
  logic                   out_valid_q;
  dfpa_pkg::out_t         out_q;
  logic                   change;
  logic [63:0]            lines_ext, trans_ext;

  assign q_pop_o     = q_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign change      = q_rec_i.price_valid && (q_rec_i.price != cur_q);

  always_comb begin
    lines_d = (lines_q != '1) ? lines_q + COUNT_WIDTH'(1) : lines_q;
    trans_d = trans_q;
    total_d = total_q;
    cur_d   = cur_q;
    if (change) begin
      total_d = total_q + {{32{cur_q[31]}}, cur_q};
      cur_d   = q_rec_i.price;
      if (trans_q != '1) trans_d = trans_q + COUNT_WIDTH'(1);
    end
  end

  assign lines_ext = 64'(lines_d);
  assign trans_ext = 64'(trans_d);

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      out_q.record_count      <= lines_ext[31:0];
      out_q.transaction_count <= trans_ext[31:0];
      out_q.total_sales       <= total_d;
      out_q.pending_amount    <= cur_d;
      out_q.price_valid       <= q_rec_i.price_valid;
      out_q.line_price        <= q_rec_i.price;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lines_q     <= '0;
      trans_q     <= '0;
      total_q     <= '0;
      cur_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        lines_q <= lines_d;
        trans_q <= trans_d;
        total_q <= total_d;
        cur_q   <= cur_d;
      end
      if (q_pop_o) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // at most one transaction per closed line
  `ASSERT_CLK(a_trans_le_lines, trans_q <= lines_q, "transaction count exceeds line count")
  `ASSERT_IMPL(a_price_pending, out_valid_q && out_q.price_valid,
               out_q.pending_amount == out_q.line_price, "pending amount not the new price")
  `ASSERT_IMPL(a_invalid_zero, out_valid_q && !out_q.price_valid,
               out_q.line_price == 32'sd0, "invalid line carries a price")

endmodule

### src/delimited_field_price_aggregator.sv
// Top level of the delimited field price aggregator.
// Depends on dfpa_pkg, dfpa_front, dfpa_fifo and dfpa_back.
//
// Usage:
//   in channel  : in_valid_i / in_ready_o / in_item_i, one text byte or an end
//                 of stream marker per item. A newline, or end of stream after
//                 at least one byte, closes the line.
//   out channel : out_valid_o / out_ready_i / out_item_o, one result per closed
//                 line carrying counters, total, pending amount and line price.
//   cfg channel : cfg_valid_i / cfg_ready_o with cfg_index_i and cfg_data_i;
//                 index 0 separator, 1 decimal mark, 2 target field; other
//                 indexes are dropped. Always ready; write only while idle.
// Throughput is one item per cycle while the queue is not full; the parser updates its line
// state in the accepting cycle with one shift-add and compare on the 64-bit magnitude.
// A summary is queued when its closing item is accepted, then moved to the output register.
// A two-entry queue holds line summaries between parser and aggregation, so
// when the receiver stalls the input keeps flowing until the queue and the
// output register are full, then in_ready_o drops.
// Reset clears control state but not stored data, loads reset values; no clearing pass.
module delimited_field_price_aggregator #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [7:0]     cfg_index_i,
  input  logic [7:0]     cfg_data_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  dfpa_pkg::in_t  in_item_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output dfpa_pkg::out_t out_item_o
);

  logic           q_full, q_push, q_pop, q_valid;
  dfpa_pkg::rec_t q_wr_rec, q_rd_rec;

  assign cfg_ready_o = 1'b1;

  dfpa_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_rec_o     (q_wr_rec)
  );

  dfpa_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .rec_i   (q_wr_rec),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rec_o   (q_rd_rec)
  );

  dfpa_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_rec_i     (q_rd_rec),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule
